FILE: rtl/edf_pkg.sv
package edf_pkg;

	localparam int unsigned MaxTasks = 8;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_START = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [3:0] REG_TASK_COUNT = 4'd0;

	// One divide job for the shared unit: dividend over a 16-bit divisor.
	typedef struct packed {
		logic        go;
		logic [47:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] quotient;
		logic [15:0] remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_HP_GCD,
		ST_HP_GCD_W,
		ST_HP_DIV,
		ST_HP_DIV_W,
		ST_HP_MUL,
		ST_SCAN,
		ST_SCAN_W,
		ST_RUN,
		ST_REL,
		ST_REL_W,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/edf_divider.sv
module edf_divider
	import edf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	// Restoring divider, one quotient bit a cycle.
	logic [47:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	always_comb begin
		shifted = {rem_q[15:0], quo_q[47]};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[15:0];

endmodule

FILE: rtl/edf_tick_scheduler_core.sv
// Channel   | Signals                                               | Direction
// ----------|-------------------------------------------------------|----------
// command   | start, req_type, task_index, arrival, exec_time,      | in
//           | period, rel_deadline; busy                            | busy out
// result    | res_valid, slot_time, running_id, done_res, all_done  | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready  | in/out
//
// Each transaction keeps busy high through a load state and an output state plus any divider
// work, and its result is strobed in the first idle cycle after that. A write, an unused
// code, a start with at most one task and a tick after the schedule has finished go straight
// from the load state to the output state. A tick runs one division per task in the deadline
// scan and again in the release pass. A start runs one division per Euclid step (up to about
// 24 per task) and one more per further task. Reset is asynchronous; the receiver cannot
// stall the result strobe.
module edf_tick_scheduler_core
	import edf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  task_index,
	input  logic [15:0] arrival,
	input  logic [15:0] exec_time,
	input  logic [15:0] period,
	input  logic [15:0] rel_deadline,
	output logic        res_valid,
	output logic [31:0] slot_time,
	output logic [3:0]  running_id,
	output logic        done_res,
	output logic        all_done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned MAX_TASKS = MaxTasks;
	localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);
	localparam logic [31:0] HpMax = 32'hFFFF_FFFF;

	state_t state_q, state_d;

	logic [15:0] arr_q [MAX_TASKS];
	logic [15:0] exe_q [MAX_TASKS];
	logic [15:0] per_q [MAX_TASKS];
	logic [15:0] dl_q  [MAX_TASKS];
	logic [15:0] rem_q [MAX_TASKS];

	logic [3:0]  tcount_q;
	logic [31:0] now_q;
	logic [31:0] hp_q;
	logic [3:0]  comp_q;
	logic [CW-1:0] n_eff;

	logic [1:0]  req_q;
	logic [2:0]  idx_in_q;
	logic [15:0] a_in_q, e_in_q, p_in_q, d_in_q;

	logic [IW-1:0] i_q;
	logic [CW-1:0] cnt_q;
	logic [47:0] hp_w_q;
	logic [47:0] ga_q;
	logic [15:0] gb_q;
	logic [15:0] g_q;
	logic          best_v_q;
	logic [IW-1:0] best_q;
	logic [32:0]   best_dl_q;
	logic [31:0]   slot_q;
	logic [3:0]    run_q;

	div_req_t dreq;
	div_rsp_t drsp;

	edf_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [15:0] per_i;
	logic [15:0] eff_p;
	logic [32:0] cand_dl;
	logic [47:0] hp_prod;
	logic        finished;
	logic        cfg_wr;

	function automatic logic [15:0] gb_next(input logic [CW-1:0] k);
		logic [15:0] p;
		p = per_q[k[IW-1:0]];
		return (p == 16'd0) ? 16'd1 : p;
	endfunction

	always_comb begin
		n_eff  = (tcount_q > 4'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(tcount_q);
		per_i  = per_q[i_q];
		eff_p  = (per_i == 16'd0) ? 16'd1 : per_i;
		cand_dl = {17'd0, dl_q[i_q]} + {1'b0, 32'(drsp.quotient[31:0]) * 32'(eff_p)};
		hp_prod = 48'(drsp.quotient[31:0]) * 48'(gb_next(cnt_q));
		finished = !(now_q < hp_q && 32'(comp_q) < 32'(n_eff));
		cfg_wr = psel && penable && pwrite && pready;
	end

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_TASK_COUNT[1:0]) ? {28'd0, tcount_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= '0;
		end else if (cfg_wr && paddr == REG_TASK_COUNT[1:0]) begin
			tcount_q <= pwdata[3:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests.
	always_comb begin
		state_d = state_q;
		dreq.go = 1'b0;
		dreq.dividend = '0;
		dreq.divisor = 16'd1;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				case (req_q)
					REQ_START: state_d = (n_eff <= CW'(1)) ? ST_OUT : ST_HP_GCD;
					REQ_TICK:  state_d = finished ? ST_OUT :
						((n_eff == '0) ? ST_RUN : ST_SCAN);
					default:   state_d = ST_OUT;
				endcase
			end
			ST_HP_GCD: begin
				if (gb_q == 16'd0) begin
					state_d = ST_HP_DIV;
				end else begin
					dreq.go = 1'b1;
					dreq.dividend = ga_q;
					dreq.divisor = gb_q;
					state_d = ST_HP_GCD_W;
				end
			end
			ST_HP_GCD_W: if (drsp.done) state_d = ST_HP_GCD;
			ST_HP_DIV: begin
				dreq.go = 1'b1;
				dreq.dividend = hp_w_q;
				dreq.divisor = g_q;
				state_d = ST_HP_DIV_W;
			end
			ST_HP_DIV_W: if (drsp.done) state_d = ST_HP_MUL;
			ST_HP_MUL: begin
				if (hp_prod >= 48'(HpMax) || cnt_q + CW'(1) >= n_eff) state_d = ST_OUT;
				else state_d = ST_HP_GCD;
			end
			ST_SCAN: begin
				dreq.go = 1'b1;
				dreq.dividend = {16'd0, now_q};
				dreq.divisor = eff_p;
				state_d = ST_SCAN_W;
			end
			ST_SCAN_W: begin
				if (drsp.done) state_d = (32'(i_q) + 1 >= 32'(n_eff)) ? ST_RUN : ST_SCAN;
			end
			ST_RUN: state_d = (n_eff == '0) ? ST_OUT : ST_REL;
			ST_REL: begin
				dreq.go = 1'b1;
				dreq.dividend = {16'd0, now_q};
				dreq.divisor = eff_p;
				state_d = ST_REL_W;
			end
			ST_REL_W: begin
				if (drsp.done) state_d = (32'(i_q) + 1 >= 32'(n_eff)) ? ST_OUT : ST_REL;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Control datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			hp_q <= '0;
			comp_q <= '0;
			res_valid <= 1'b0;
			for (int k = 0; k < MAX_TASKS; k++) rem_q[k] <= '0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (req_q == REQ_START) begin
						for (int k = 0; k < MAX_TASKS; k++)
							if (k < int'(n_eff)) rem_q[k] <= exe_q[k];
						now_q <= '0;
						comp_q <= '0;
						if (n_eff == '0) hp_q <= '0;
						else hp_q <= {16'd0, (per_q[0] == 16'd0) ? 16'd1 : per_q[0]};
					end
				end
				ST_HP_MUL: begin
					if (hp_prod >= 48'(HpMax)) hp_q <= HpMax;
					else hp_q <= hp_prod[31:0];
				end
				ST_RUN: begin
					if (best_v_q) begin
						rem_q[best_q] <= rem_q[best_q] - 16'd1;
						if (rem_q[best_q] == 16'd1) comp_q <= comp_q + 4'd1;
					end
					now_q <= now_q + 32'd1;
				end
				ST_REL_W: begin
					if (drsp.done && drsp.remainder == 16'd0) rem_q[i_q] <= exe_q[i_q];
				end
				ST_OUT: res_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload and sequencing registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req_type;
				idx_in_q <= task_index;
				a_in_q <= arrival;
				e_in_q <= exec_time;
				p_in_q <= period;
				d_in_q <= rel_deadline;
			end
			ST_LOAD: begin
				i_q <= '0;
				best_v_q <= 1'b0;
				best_q <= '0;
				best_dl_q <= '0;
				run_q <= 4'd0;
				slot_q <= (req_q == REQ_START) ? 32'd0 : now_q;
				cnt_q <= CW'(1);
				hp_w_q <= {32'd0, (per_q[0] == 16'd0) ? 16'd1 : per_q[0]};
				ga_q <= {32'd0, (per_q[0] == 16'd0) ? 16'd1 : per_q[0]};
				gb_q <= (per_q[1 % MAX_TASKS] == 16'd0) ? 16'd1 : per_q[1 % MAX_TASKS];
				if (req_q == REQ_WRITE && 32'(idx_in_q) < 32'(MAX_TASKS)) begin
					arr_q[idx_in_q[IW-1:0]] <= a_in_q;
					exe_q[idx_in_q[IW-1:0]] <= e_in_q;
					per_q[idx_in_q[IW-1:0]] <= p_in_q;
					dl_q[idx_in_q[IW-1:0]]  <= d_in_q;
				end
			end
			ST_HP_GCD: if (gb_q == 16'd0) g_q <= ga_q[15:0];
			ST_HP_GCD_W: begin
				if (drsp.done) begin
					ga_q <= {32'd0, gb_q};
					gb_q <= drsp.remainder;
				end
			end
			// Feed the next GCD with the latest hyperperiod and the next period.
			ST_HP_MUL: begin
				hp_w_q <= hp_prod;
				ga_q <= hp_prod;
				gb_q <= gb_next(cnt_q + CW'(1));
				cnt_q <= cnt_q + CW'(1);
			end
			ST_SCAN_W: begin
				if (drsp.done) begin
					if ({16'd0, arr_q[i_q]} <= now_q && rem_q[i_q] != 16'd0 &&
					    (!best_v_q || cand_dl < best_dl_q)) begin
						best_v_q <= 1'b1;
						best_q <= i_q;
						best_dl_q <= cand_dl;
					end
					i_q <= i_q + IW'(1);
				end
			end
			ST_RUN: begin
				i_q <= '0;
				run_q <= best_v_q ? 4'(best_q) + 4'd1 : 4'd0;
			end
			ST_REL_W: if (drsp.done) i_q <= i_q + IW'(1);
			default: ;
		endcase
	end

	assign slot_time  = slot_q;
	assign running_id = run_q;
	assign done_res   = finished;
	assign all_done   = (32'(comp_q) == 32'(n_eff));

endmodule

FILE: test/tb_edf_tick_scheduler_core.sv
module tb_edf_tick_scheduler_core
	import edf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NTASKS    = 8;
	localparam longint unsigned HPSAT = 64'hFFFF_FFFF;
	localparam int unsigned CYCLE_CAP = 4_000_000;
	localparam int unsigned SETTLE    = 2000;

	typedef struct packed {
		logic [31:0] slot;
		logic [3:0]  run_id;
		logic        done;
		logic        all;
	} slot_report_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req_type;
	logic [2:0]  task_index;
	logic [15:0] arrival;
	logic [15:0] exec_time;
	logic [15:0] period;
	logic [15:0] rel_deadline;
	logic        res_valid;
	logic [31:0] slot_time;
	logic [3:0]  running_id;
	logic        done_res;
	logic        all_done;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Scheduler shadow state kept by the testbench.
	logic [15:0] sh_arrival [NTASKS];
	logic [15:0] sh_exec [NTASKS];
	logic [15:0] sh_period [NTASKS];
	logic [15:0] sh_deadline [NTASKS];
	logic [15:0] sh_left [NTASKS];
	logic [31:0] sh_now;
	int unsigned sh_completed;
	logic [31:0] sh_hyper;
	logic [3:0]  sh_count;

	slot_report_t pending_reports [$];
	int unsigned  mismatches;
	int unsigned  reports_seen;
	int unsigned  items_sent;
	int unsigned  busy_slots;
	int unsigned  cycles;

	edf_tick_scheduler_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.task_index  (task_index),
		.arrival     (arrival),
		.exec_time   (exec_time),
		.period      (period),
		.rel_deadline(rel_deadline),
		.res_valid   (res_valid),
		.slot_time   (slot_time),
		.running_id  (running_id),
		.done_res    (done_res),
		.all_done    (all_done),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int unsigned live_tasks();
		return (sh_count > NTASKS) ? NTASKS : int'(sh_count);
	endfunction

	function automatic logic [31:0] eff_period(int i);
		return (sh_period[i] == 16'd0) ? 32'd1 : {16'd0, sh_period[i]};
	endfunction

	// Least common multiple of the live periods, saturating at 32 bits.
	function automatic logic [31:0] lcm_of_periods(int unsigned n);
		longint unsigned acc;
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		if (n == 0)
			return 32'd0;
		acc = eff_period(0);
		for (int i = 1; i < n; i++) begin
			a = acc;
			b = eff_period(i);
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			acc = (acc / a) * eff_period(i);
			if (acc >= HPSAT)
				return 32'hFFFF_FFFF;
		end
		return acc[31:0];
	endfunction

	function automatic logic schedule_over();
		return !(sh_now < sh_hyper && sh_completed < live_tasks());
	endfunction

	// Applies one transaction to the shadow state and returns the expected report.
	function automatic slot_report_t edf_step(req_t rq, logic [2:0] idx, logic [15:0] a,
			logic [15:0] e, logic [15:0] p, logic [15:0] d);
		slot_report_t rep;
		int unsigned n;
		int best;
		longint unsigned best_dl;
		longint unsigned dl;
		n = live_tasks();
		rep.slot = sh_now;
		rep.run_id = 4'd0;
		if (rq == REQ_WRITE) begin
			sh_arrival[idx] = a;
			sh_exec[idx] = e;
			sh_period[idx] = p;
			sh_deadline[idx] = d;
		end else if (rq == REQ_START) begin
			for (int i = 0; i < n; i++)
				sh_left[i] = sh_exec[i];
			sh_now = 32'd0;
			sh_completed = 0;
			sh_hyper = lcm_of_periods(n);
			rep.slot = 32'd0;
		end else if (rq == REQ_TICK && !schedule_over()) begin
			best = -1;
			best_dl = 0;
			for (int i = 0; i < n; i++) begin
				if ({16'd0, sh_arrival[i]} <= sh_now && sh_left[i] != 16'd0) begin
					dl = longint'(sh_deadline[i]) +
						longint'((sh_now / eff_period(i)) * eff_period(i));
					if (best < 0 || dl < best_dl) begin
						best = i;
						best_dl = dl;
					end
				end
			end
			if (best >= 0) begin
				sh_left[best] = sh_left[best] - 16'd1;
				if (sh_left[best] == 16'd0)
					sh_completed++;
				rep.run_id = 4'(best + 1);
			end
			sh_now = sh_now + 32'd1;
			for (int i = 0; i < n; i++)
				if (sh_now % eff_period(i) == 0)
					sh_left[i] = sh_exec[i];
		end
		rep.done = schedule_over();
		rep.all = (sh_completed == n);
		return rep;
	endfunction

	// Result checker: every strobe is compared with the oldest expected report.
	always @(posedge clk) begin
		slot_report_t want;
		if (arst_n && res_valid) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: slot %0d id %0d",
						slot_time, running_id);
			end else begin
				want = pending_reports.pop_front();
				if (slot_time !== want.slot || running_id !== want.run_id ||
						done_res !== want.done || all_done !== want.all) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected slot %0d id %0d done %0b all %0b, got slot %0d id %0d done %0b all %0b",
							want.slot, want.run_id, want.done, want.all,
							slot_time, running_id, done_res, all_done);
				end
			end
		end
	end

	// Sends one command transaction and records its expected report once accepted.
	task automatic send_cmd(req_t rq, logic [2:0] idx, logic [15:0] a, logic [15:0] e,
			logic [15:0] p, logic [15:0] d);
		@(negedge clk);
		start = 1'b1;
		req_type = rq;
		task_index = idx;
		arrival = a;
		exec_time = e;
		period = p;
		rel_deadline = d;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
			busy_slots++;
		end
		pending_reports.push_back(edf_step(rq, idx, a, e, p, d));
		items_sent++;
	endtask

	// Random idle time between commands: mostly none or short, now and then long.
	task automatic sender_gap();
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			len = 0;
		else if (pick < 92)
			len = $urandom_range(1, 4);
		else
			len = $urandom_range(20, 80);
		if (len > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (len - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	// Writes the task count register while the block is idle and reads it back.
	task automatic write_task_count(logic [3:0] v);
		wait_drained();
		repeat (20) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = REG_TASK_COUNT[1:0];
		pwdata = {28'd0, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sh_count = v;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[3:0] !== v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Task count read back: expected %0d, got %0d", v, prdata[3:0]);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_entry(logic [2:0] idx, logic wide);
		if (wide)
			send_cmd(REQ_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		else
			send_cmd(REQ_WRITE, idx, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
				16'($urandom_range(0, 12)), 16'($urandom_range(0, 15)));
	endtask

	// Directed cases: extremes, every request code, ties and degenerate tasks.
	task automatic test_directed();
		send_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(REQ_WRITE, 3'd0, 16'd0, 16'd2, 16'd4, 16'd3);
		send_cmd(REQ_WRITE, 3'd1, 16'd0, 16'd1, 16'd0, 16'd3);
		send_cmd(REQ_WRITE, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cmd(REQ_WRITE, 3'd3, 16'd0, 16'd0, 16'd3, 16'd0);
		send_cmd(REQ_WRITE, 3'd4, 16'd1, 16'd2, 16'd6, 16'd5);
		send_cmd(REQ_WRITE, 3'd5, 16'd0, 16'd1, 16'd2, 16'd1);
		send_cmd(REQ_WRITE, 3'd6, 16'd2, 16'd3, 16'd8, 16'd8);
		send_cmd(REQ_WRITE, 3'd7, 16'd0, 16'd1, 16'd1, 16'd0);
		send_cmd(REQ_NONE, 3'd7, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		send_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_task_count(4'd2);
		send_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (5) send_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_task_count(4'd8);
		send_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (6) send_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	// Random schedules: reload part of the table, restart, then tick with some noise.
	task automatic test_random_schedules(int unsigned target);
		int unsigned pick;
		int unsigned ticks;
		int unsigned phase;
		phase = 0;
		while (items_sent < target) begin
			pick = $urandom_range(0, 9);
			if (phase % 7 == 3)
				write_task_count(4'd0);
			else if (phase % 7 == 5)
				write_task_count(4'd8);
			else
				write_task_count(4'($urandom_range(1, 8)));
			repeat ($urandom_range(1, 5)) begin
				send_entry(3'($urandom_range(0, 7)), $urandom_range(0, 9) == 0);
				sender_gap();
			end
			send_cmd(REQ_START, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
			ticks = $urandom_range(15, 60);
			repeat (ticks) begin
				pick = $urandom_range(0, 99);
				if (pick < 88)
					send_cmd(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				else if (pick < 94)
					send_entry(3'($urandom_range(0, 7)), 1'b0);
				else if (pick < 97)
					send_cmd(REQ_NONE, 3'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				else
					send_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				sender_gap();
			end
			if (phase == 2)
				wait_drained();
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WRITE;
		task_index = '0;
		arrival = '0;
		exec_time = '0;
		period = '0;
		rel_deadline = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		mismatches = 0;
		reports_seen = 0;
		items_sent = 0;
		busy_slots = 0;
		sh_now = '0;
		sh_completed = 0;
		sh_hyper = '0;
		sh_count = '0;
		for (int i = 0; i < NTASKS; i++) begin
			sh_arrival[i] = '0;
			sh_exec[i] = '0;
			sh_period[i] = '0;
			sh_deadline[i] = '0;
			sh_left[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_schedules(650);

		// Let the last transaction finish, then allow the block to settle.
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d commands (%0d results checked, %0d busy cycles seen) over",
			items_sent, reports_seen, busy_slots);
		$display("task counts 0 to 8, degenerate periods and execution times, restarts.");
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/edf_pkg.sv
rtl/edf_divider.sv
rtl/edf_tick_scheduler_core.sv
test/tb_edf_tick_scheduler_core.sv
